// File: hw/rtl/pgn_pkg.sv
// ----------------------------------------------------------------------------
// pgn_pkg
// Shared constants, permutation ROM and gradient helpers for the gradient
// noise pipeline.
// ----------------------------------------------------------------------------
package pgn_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int COORD_W = 32;
    localparam int NOISE_W = 16;
    localparam int CELL_W  = 8;
    localparam int Q16_W   = 16;       // fraction in Q16
    localparam int FADE_W  = 17;       // fade in [0, 1.0] Q16
    localparam int OFS_W   = 18;       // corner offset, signed
    localparam int VAL_W   = 20;       // dot products and blends, signed

    localparam int ONE_Q16  = 65536;
    localparam int HALF_Q16 = 32768;

    localparam logic [7:0] PERM_ROM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
        8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
        8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
        8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
        8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
        8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
        8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
        8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
        8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
        8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
        8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
        8'd215,8'd61,8'd156,8'd180
    };

    // hash mod 12 via reciprocal multiply (exact for 8-bit values)
    function automatic logic [3:0] mod12(input logic [7:0] h);
        logic [15:0] m;
        logic [4:0]  q;
        logic [7:0]  qx;
        m  = 16'(h) * 16'd171;
        q  = m[15:11];
        qx = 8'(q) * 8'd12;
        return 4'(h - qx);
    endfunction

    // two-axis gradient: +x, -x, +y, -y
    function automatic logic signed [VAL_W-1:0] dot2(input logic [7:0] h,
        input logic signed [OFS_W-1:0] dx, input logic signed [OFS_W-1:0] dy);
        logic signed [VAL_W-1:0] ex;
        logic signed [VAL_W-1:0] ey;
        ex = VAL_W'(dx);
        ey = VAL_W'(dy);
        case (h[1:0])
            2'd0:    return ex;
            2'd1:    return -ex;
            2'd2:    return ey;
            default: return -ey;
        endcase
    endfunction

    // cube-edge gradient selected by hash mod 12
    function automatic logic signed [VAL_W-1:0] dot3(input logic [7:0] h,
        input logic signed [OFS_W-1:0] dx, input logic signed [OFS_W-1:0] dy,
        input logic signed [OFS_W-1:0] dz);
        logic signed [VAL_W-1:0] ex;
        logic signed [VAL_W-1:0] ey;
        logic signed [VAL_W-1:0] ez;
        ex = VAL_W'(dx);
        ey = VAL_W'(dy);
        ez = VAL_W'(dz);
        case (mod12(h))
            4'd0:    return  ex + ey;
            4'd1:    return -ex + ey;
            4'd2:    return  ex - ey;
            4'd3:    return -ex - ey;
            4'd4:    return  ex + ez;
            4'd5:    return -ex + ez;
            4'd6:    return  ex - ez;
            4'd7:    return -ex - ez;
            4'd8:    return  ey + ez;
            4'd9:    return -ey + ez;
            4'd10:   return  ey - ez;
            default: return -ey - ez;
        endcase
    endfunction

endpackage

// File: hw/rtl/pgn_sample_if.sv
// ----------------------------------------------------------------------------
// pgn_sample_if
// Sample point channel: three Q fixed-point coordinates.
// ----------------------------------------------------------------------------
interface pgn_sample_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   coord_x;
    logic signed [31:0]   coord_y;
    logic signed [31:0]   coord_z;

    modport source (output valid, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

// File: hw/rtl/pgn_noise_if.sv
// ----------------------------------------------------------------------------
// pgn_noise_if
// Result channel: one Q1.14 noise sample.
// ----------------------------------------------------------------------------
interface pgn_noise_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

// File: hw/rtl/pgn_cfg_if.sv
// ----------------------------------------------------------------------------
// pgn_cfg_if
// Configuration write channel for the dimension mode register.
// ----------------------------------------------------------------------------
interface pgn_cfg_if;
    logic valid;
    logic ready;
    logic dimension_mode;

    modport source (output valid, dimension_mode, input ready);
    modport sink   (input valid, dimension_mode, output ready);
endinterface

// File: hw/rtl/pgn_fade.sv
// ----------------------------------------------------------------------------
// pgn_fade
// Three-stage quintic fade 6t^5-15t^4+10t^3 in Q16, clamped to [0, 1.0].
// ----------------------------------------------------------------------------
module pgn_fade (
    input  logic                        clk,
    input  logic                        en,
    input  logic [pgn_pkg::Q16_W-1:0]   t,
    output logic [pgn_pkg::FADE_W-1:0]  f
);
    import pgn_pkg::*;

    logic [16:0]        tt_reg;
    logic [15:0]        t_reg;
    logic signed [21:0] pr_reg;
    logic [16:0]        t3_reg;
    logic signed [21:0] inner_reg;
    logic [FADE_W-1:0]  f_reg;

    logic signed [21:0] s6;
    logic signed [39:0] p_prod;
    logic [33:0]        t3_prod;
    logic signed [39:0] f_prod;
    logic signed [39:0] f_rnd;

    always_comb
    begin
        s6      = 22'sd6 * $signed({6'd0, t}) - 22'sd983040;
        p_prod  = $signed({24'd0, t}) * 40'(s6);
        t3_prod = 34'(tt_reg) * 34'(t_reg);
        f_prod  = $signed({23'd0, t3_reg}) * 40'(inner_reg);
        f_rnd   = (f_prod + 40'sd32768) >>> 16;
    end

    // stage 1: t^2 and t*(6t-15); stage 2: t^3 and inner; stage 3: product, clamp
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tt_reg    <= 17'((34'(t) * 34'(t) + 34'd32768) >> 16);
            t_reg     <= t;
            pr_reg    <= 22'((p_prod + 40'sd32768) >>> 16);
            t3_reg    <= 17'((t3_prod + 34'd32768) >> 16);
            inner_reg <= pr_reg + 22'sd655360;
            if (f_rnd < 0)
                f_reg <= '0;
            else if (f_rnd > 40'sd65536)
                f_reg <= FADE_W'(ONE_Q16);
            else
                f_reg <= FADE_W'(f_rnd);
        end
    end

    assign f = f_reg;
endmodule

// File: hw/rtl/pgn_lerp.sv
// ----------------------------------------------------------------------------
// pgn_lerp
// Registered linear blend a + (b-a)*w with Q16 rounding.
// ----------------------------------------------------------------------------
module pgn_lerp (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [pgn_pkg::VAL_W-1:0]  a,
    input  logic signed [pgn_pkg::VAL_W-1:0]  b,
    input  logic [pgn_pkg::FADE_W-1:0]        w,
    output logic signed [pgn_pkg::VAL_W-1:0]  y
);
    import pgn_pkg::*;

    logic signed [VAL_W:0]   diff;
    logic signed [39:0]      prod;
    logic signed [39:0]      q;
    logic signed [VAL_W-1:0] y_reg;

    always_comb
    begin
        diff = (VAL_W+1)'(b) - (VAL_W+1)'(a);
        prod = 40'(diff) * $signed({23'd0, w});
        q    = (prod + 40'sd32768) >>> 16;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            y_reg <= a + VAL_W'(q);
    end

    assign y = y_reg;
endmodule

// File: hw/rtl/perlin_gradient_noise.sv
// ----------------------------------------------------------------------------
// perlin_gradient_noise
// 2D/3D gradient noise pipeline over a fixed permutation ROM.
// A sample passes the split, lookup, hash, dot-product, blend and output registers in order.
// Throughput: one sample per cycle; the whole pipe holds when the output
// register is full and not taken, so ready follows the output side.
// Reset clears the valid bits and dimension_mode (2D); data regs are not reset.
// ----------------------------------------------------------------------------
module perlin_gradient_noise #(
    parameter int FRAC_BITS = pgn_pkg::FRAC_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    pgn_sample_if.sink   sample,
    pgn_noise_if.source  noise,
    pgn_cfg_if.sink      cfg
);
    import pgn_pkg::*;

    localparam int SH_R = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SH_L = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
    localparam int NSTG = 9;

    logic             mode_reg;
    logic [NSTG:1]    vld_reg;
    logic             advance;

    // stage 1: split coordinates
    logic [7:0]  cx_reg, cy_reg, cz_reg;
    logic [15:0] fx_reg, fy_reg, fz_reg;
    logic        m1_reg;
    // stage 2: first lookups
    logic [7:0]  px_reg [2];
    logic [7:0]  yc2_reg [2];
    logic [7:0]  zc2_reg [2];
    logic [15:0] fx2_reg, fy2_reg, fz2_reg;
    logic        m2_reg;
    // stage 3: 2D hashes
    logic [7:0]  h2_reg [4];
    logic [7:0]  zc3_reg [2];
    logic [15:0] fx3_reg, fy3_reg, fz3_reg;
    logic        m3_reg;
    // stage 4: 3D hashes
    logic [7:0]  h2d_reg [4];
    logic [7:0]  h3_reg [8];
    logic [15:0] fx4_reg, fy4_reg, fz4_reg;
    logic        m4_reg;
    // stage 5: corner dot products
    logic signed [VAL_W-1:0] dot_reg [8];
    logic [FADE_W-1:0]       u5_reg, v5_reg, w5_reg;
    logic                    m5_reg;
    // stages 6..8: blends
    logic signed [VAL_W-1:0] l1 [4];
    logic signed [VAL_W-1:0] l2 [2];
    logic signed [VAL_W-1:0] l3;
    logic [FADE_W-1:0]       v6_reg, w6_reg, w7_reg;
    logic                    m6_reg, m7_reg, m8_reg;
    logic signed [VAL_W-1:0] c0_8_reg;
    // stage 9: output
    logic signed [NOISE_W-1:0] out_reg;

    logic [FADE_W-1:0]       fu, fv, fw;
    logic [31:0]             lx, ly, lz;
    logic signed [VAL_W-1:0] dot_next [8];
    logic signed [VAL_W+1:0] rnd;
    logic signed [VAL_W-1:0] res;

    assign advance      = !vld_reg[NSTG] || noise.ready;
    assign sample.ready = advance;
    assign cfg.ready    = 1'b1;
    assign noise.valid  = vld_reg[NSTG];
    assign noise.noise_value = out_reg;

    // control: mode register and stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            vld_reg  <= '0;
        end
        else
        begin
            if (cfg.valid)
                mode_reg <= cfg.dimension_mode;
            if (advance)
                vld_reg <= {vld_reg[NSTG-1:1], sample.valid};
        end
    end

    // fraction bits brought to Q16
    always_comb
    begin
        lx = 32'(sample.coord_x[FRAC_BITS-1:0]);
        ly = 32'(sample.coord_y[FRAC_BITS-1:0]);
        lz = 32'(sample.coord_z[FRAC_BITS-1:0]);
    end

    // stages 1..4: split and hash chain
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cx_reg <= sample.coord_x[FRAC_BITS+7:FRAC_BITS];
            cy_reg <= sample.coord_y[FRAC_BITS+7:FRAC_BITS];
            cz_reg <= sample.coord_z[FRAC_BITS+7:FRAC_BITS];
            fx_reg <= 16'((lx >> SH_R) << SH_L);
            fy_reg <= 16'((ly >> SH_R) << SH_L);
            fz_reg <= 16'((lz >> SH_R) << SH_L);
            m1_reg <= mode_reg;

            px_reg[0]  <= PERM_ROM[cx_reg];
            px_reg[1]  <= PERM_ROM[cx_reg + 8'd1];
            yc2_reg[0] <= cy_reg;
            yc2_reg[1] <= cy_reg + 8'd1;
            zc2_reg[0] <= cz_reg;
            zc2_reg[1] <= cz_reg + 8'd1;
            fx2_reg <= fx_reg;
            fy2_reg <= fy_reg;
            fz2_reg <= fz_reg;
            m2_reg  <= m1_reg;

            for (int c = 0; c < 4; c++)
                h2_reg[c] <= PERM_ROM[px_reg[c % 2] + yc2_reg[c / 2]];
            zc3_reg <= zc2_reg;
            fx3_reg <= fx2_reg;
            fy3_reg <= fy2_reg;
            fz3_reg <= fz2_reg;
            m3_reg  <= m2_reg;

            for (int c = 0; c < 8; c++)
                h3_reg[c] <= PERM_ROM[h2_reg[c % 4] + zc3_reg[c / 4]];
            h2d_reg <= h2_reg;
            fx4_reg <= fx3_reg;
            fy4_reg <= fy3_reg;
            fz4_reg <= fz3_reg;
            m4_reg  <= m3_reg;
        end
    end

    // fade curves, aligned with stage 4
    pgn_fade u_fade_x (.clk(clk), .en(advance), .t(fx_reg), .f(fu));
    pgn_fade u_fade_y (.clk(clk), .en(advance), .t(fy_reg), .f(fv));
    pgn_fade u_fade_z (.clk(clk), .en(advance), .t(fz_reg), .f(fw));

    // corner gradients dotted with corner offsets
    always_comb
    begin
        logic signed [OFS_W-1:0] dx, dy, dz;
        for (int c = 0; c < 8; c++)
        begin
            dx = $signed({2'b00, fx4_reg}) - ((c % 2 == 1) ? OFS_W'(ONE_Q16) : '0);
            dy = $signed({2'b00, fy4_reg}) - (((c / 2) % 2 == 1) ? OFS_W'(ONE_Q16) : '0);
            dz = $signed({2'b00, fz4_reg}) - ((c / 4 == 1) ? OFS_W'(ONE_Q16) : '0);
            if (m4_reg)
                dot_next[c] = dot3(h3_reg[c], dx, dy, dz);
            else
                dot_next[c] = dot2(h2d_reg[c % 4], dx, dy);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dot_reg <= dot_next;
            u5_reg  <= fu;
            v5_reg  <= fv;
            w5_reg  <= fw;
            m5_reg  <= m4_reg;
            v6_reg  <= v5_reg;
            w6_reg  <= w5_reg;
            m6_reg  <= m5_reg;
            w7_reg  <= w6_reg;
            m7_reg  <= m6_reg;
            m8_reg  <= m7_reg;
            c0_8_reg <= l2[0];
        end
    end

    // blend tree: x, then y, then z
    for (genvar k = 0; k < 4; k++)
    begin : g_lx
        pgn_lerp u_lerp (.clk(clk), .en(advance), .a(dot_reg[2*k]), .b(dot_reg[2*k+1]),
                         .w(u5_reg), .y(l1[k]));
    end
    for (genvar k = 0; k < 2; k++)
    begin : g_ly
        pgn_lerp u_lerp (.clk(clk), .en(advance), .a(l1[2*k]), .b(l1[2*k+1]),
                         .w(v6_reg), .y(l2[k]));
    end
    pgn_lerp u_lerp_z (.clk(clk), .en(advance), .a(l2[0]), .b(l2[1]), .w(w7_reg), .y(l3));

    // output rounding to Q1.14 and saturation
    always_comb
    begin
        res = m8_reg ? l3 : c0_8_reg;
        rnd = ((VAL_W+2)'(res) + (VAL_W+2)'(2)) >>> 2;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (rnd > (VAL_W+2)'(32767))
                out_reg <= 16'sh7fff;
            else if (rnd < -(VAL_W+2)'(32768))
                out_reg <= 16'sh8000;
            else
                out_reg <= NOISE_W'(rnd);
        end
    end

    // checks
    a_in_enters: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> vld_reg[1])
        else $error("accepted sample did not enter stage 1");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && vld_reg[NSTG-1] |=> noise.valid)
        else $error("result lost at output stage");
    a_fade: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> (fu <= FADE_W'(ONE_Q16)) && (fv <= FADE_W'(ONE_Q16)))
        else $error("fade out of range");
endmodule
